@@ rtl/clin_pkg.sv @@
// clin_pkg: shared constants and types for the clamped linear interpolator
// no dependencies; imported by every clin module
`timescale 1ns / 1ps
`default_nettype none

package clin_pkg;

  // default sample / register width
  localparam int DATA_WIDTH = 16;

  // configuration register indexes
  localparam int REG_INDEX_WIDTH = 2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_INPUT_LOW   = 2'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_INPUT_HIGH  = 2'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_OUTPUT_LOW  = 2'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_OUTPUT_HIGH = 2'd3;

  // reset value of the two upper end points, cut to the data width
  localparam logic [31:0] RESET_HIGH = 32'd65535;

  // control travelling with each pipeline stage
  typedef struct packed {
    logic valid;  // stage holds a transaction
    logic clamp;  // result is the end point held in base
    logic desc;   // output span is descending
  } clin_ctl_t;

endpackage

`default_nettype wire

@@ rtl/clin_front.sv @@
// clin_front: clamp decision, differences and span product (two register stages)
// depends on clin_pkg
`timescale 1ns / 1ps
`default_nettype none

module clin_front #(
  parameter int DATA_WIDTH = clin_pkg::DATA_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [DATA_WIDTH-1:0]     sample,
  input  wire logic [DATA_WIDTH-1:0]     input_low,
  input  wire logic [DATA_WIDTH-1:0]     input_high,
  input  wire logic [DATA_WIDTH-1:0]     output_low,
  input  wire logic [DATA_WIDTH-1:0]     output_high,
  output clin_pkg::clin_ctl_t            ctl_out,
  output logic      [2*DATA_WIDTH-1:0]   prod_out,
  output logic      [DATA_WIDTH-1:0]     div_out,
  output logic      [DATA_WIDTH-1:0]     base_out
);
  import clin_pkg::*;

  logic                  at_high;
  logic                  at_low;
  logic                  desc_c;
  logic [DATA_WIDTH-1:0] dx_c;
  logic [DATA_WIDTH-1:0] div_c;
  logic [DATA_WIDTH-1:0] mag_c;
  logic [DATA_WIDTH-1:0] base_c;

  // stage a registers
  clin_ctl_t             ctl_a;
  logic [DATA_WIDTH-1:0] dx_a;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] div_a;
  logic [DATA_WIDTH-1:0] base_a;

  // stage b registers
  clin_ctl_t             ctl_b;
  logic [2*DATA_WIDTH-1:0] prod_b;
  logic [DATA_WIDTH-1:0] div_b;
  logic [DATA_WIDTH-1:0] base_b;

  // clamp tests, upper end point first, and the differences in parallel
  always_comb begin
    at_high = (sample >= input_high);
    at_low  = (sample <= input_low);
    desc_c  = (output_high < output_low);
    dx_c    = sample - input_low;
    div_c   = input_high - input_low;
    mag_c   = desc_c ? (output_low - output_high) : (output_high - output_low);
    base_c  = at_high ? output_high : output_low;
  end

  // stage a control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a.valid <= in_valid;
      ctl_a.clamp <= at_high | at_low;
      ctl_a.desc  <= desc_c;
    end
  end

  // stage a payload
  always_ff @(posedge clk) begin
    if (en) begin
      dx_a   <= dx_c;
      mag_a  <= mag_c;
      div_a  <= div_c;
      base_a <= base_c;
    end
  end

  // stage b control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else if (en) begin
      ctl_b <= ctl_a;
    end
  end

  // stage b payload: full width product, no wrap
  always_ff @(posedge clk) begin
    if (en) begin
      prod_b <= (2*DATA_WIDTH)'(dx_a) * (2*DATA_WIDTH)'(mag_a);
      div_b  <= div_a;
      base_b <= base_a;
    end
  end

  assign ctl_out  = ctl_b;
  assign prod_out = prod_b;
  assign div_out  = div_b;
  assign base_out = base_b;

endmodule

`default_nettype wire

@@ rtl/clin_div.sv @@
// clin_div: pipelined restoring divider, one quotient bit per register stage
// depends on clin_pkg
`timescale 1ns / 1ps
`default_nettype none

module clin_div #(
  parameter int DATA_WIDTH = clin_pkg::DATA_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire clin_pkg::clin_ctl_t       ctl_in,
  input  wire logic [2*DATA_WIDTH-1:0]   prod_in,
  input  wire logic [DATA_WIDTH-1:0]     div_in,
  input  wire logic [DATA_WIDTH-1:0]     base_in,
  output clin_pkg::clin_ctl_t            ctl_out,
  output logic      [DATA_WIDTH-1:0]     quot_out,
  output logic      [DATA_WIDTH-1:0]     base_out
);
  import clin_pkg::*;

  // one register set per quotient bit
  clin_ctl_t             ctl_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] low_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quot_r [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] div_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] base_r [DATA_WIDTH];

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    clin_ctl_t             ctl_s;
    logic [DATA_WIDTH-1:0] rem_s;
    logic [DATA_WIDTH-1:0] low_s;
    logic [DATA_WIDTH-1:0] quot_s;
    logic [DATA_WIDTH-1:0] div_s;
    logic [DATA_WIDTH-1:0] base_s;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;

    // first step takes the product: upper half is below the divisor
    if (i == 0) begin : g_first
      assign ctl_s  = ctl_in;
      assign rem_s  = prod_in[2*DATA_WIDTH-1:DATA_WIDTH];
      assign low_s  = prod_in[DATA_WIDTH-1:0];
      assign quot_s = '0;
      assign div_s  = div_in;
      assign base_s = base_in;
    end else begin : g_next
      assign ctl_s  = ctl_r[i-1];
      assign rem_s  = rem_r[i-1];
      assign low_s  = low_r[i-1];
      assign quot_s = quot_r[i-1];
      assign div_s  = div_r[i-1];
      assign base_s = base_r[i-1];
    end

    // shift in the next product bit and try the subtraction
    assign trial = {rem_s, low_s[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, div_s};

    // control
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_s;
      end
    end

    // payload: keep the difference when it did not borrow
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        low_r[i]  <= {low_s[DATA_WIDTH-2:0], 1'b0};
        quot_r[i] <= {quot_s[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        div_r[i]  <= div_s;
        base_r[i] <= base_s;
      end
    end
  end

  assign ctl_out  = ctl_r[DATA_WIDTH-1];
  assign quot_out = quot_r[DATA_WIDTH-1];
  assign base_out = base_r[DATA_WIDTH-1];

endmodule

`default_nettype wire

@@ rtl/clamped_linear_interpolator_top.sv @@
// clamped_linear_interpolator_top: configuration registers, pipeline and output register
// depends on clin_pkg, clin_front, clin_div
`timescale 1ns / 1ps
`default_nettype none

// Clamped linear interpolator. Each sample is mapped to
// output_low + (sample - input_low) * (output_high - output_low) / (input_high - input_low),
// truncated toward zero, or to output_high / output_low when it lies at or beyond an input
// end point. One transaction is accepted per clock while in_ready is high; each passes
// through two front stages (clamp test, then the full width span product), DATA_WIDTH
// stages of the restoring divider (one quotient bit each) and the output register. The
// whole pipeline holds when a result is waiting and out_ready is low, so in_ready follows
// out_ready in that case. Registers are written through cfg_wr_en, cfg_index and cfg_data,
// and should be changed only while no transaction is in flight.

module clamped_linear_interpolator_top #(
  parameter int DATA_WIDTH = clin_pkg::DATA_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [clin_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [DATA_WIDTH-1:0]                 cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [DATA_WIDTH-1:0]                 sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [DATA_WIDTH-1:0]                 scaled
);
  import clin_pkg::*;

  logic                  en;
  logic [DATA_WIDTH-1:0] input_low;
  logic [DATA_WIDTH-1:0] input_high;
  logic [DATA_WIDTH-1:0] output_low;
  logic [DATA_WIDTH-1:0] output_high;

  clin_ctl_t               front_ctl;
  logic [2*DATA_WIDTH-1:0] front_prod;
  logic [DATA_WIDTH-1:0]   front_div;
  logic [DATA_WIDTH-1:0]   front_base;

  clin_ctl_t             div_ctl;
  logic [DATA_WIDTH-1:0] div_quot;
  logic [DATA_WIDTH-1:0] div_base;
  logic [DATA_WIDTH-1:0] scaled_next;

  // pipeline advances unless a finished result is held
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_low   <= '0;
      input_high  <= DATA_WIDTH'(RESET_HIGH);
      output_low  <= '0;
      output_high <= DATA_WIDTH'(RESET_HIGH);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INPUT_LOW:   input_low   <= cfg_data;
        REG_INPUT_HIGH:  input_high  <= cfg_data;
        REG_OUTPUT_LOW:  output_low  <= cfg_data;
        REG_OUTPUT_HIGH: output_high <= cfg_data;
        default: ;
      endcase
    end
  end

  clin_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .sample      (sample),
    .input_low   (input_low),
    .input_high  (input_high),
    .output_low  (output_low),
    .output_high (output_high),
    .ctl_out     (front_ctl),
    .prod_out    (front_prod),
    .div_out     (front_div),
    .base_out    (front_base)
  );

  clin_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (front_ctl),
    .prod_in  (front_prod),
    .div_in   (front_div),
    .base_in  (front_base),
    .ctl_out  (div_ctl),
    .quot_out (div_quot),
    .base_out (div_base)
  );

  // apply the quotient to output_low, or pass the clamped end point
  always_comb begin
    if (div_ctl.clamp) begin
      scaled_next = div_base;
    end else if (div_ctl.desc) begin
      scaled_next = div_base - div_quot;
    end else begin
      scaled_next = div_base + div_quot;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_ctl.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= scaled_next;
    end
  end

endmodule

`default_nettype wire
